@@ hdl/sfu_pkg.sv @@
// ----------------------------------------------------------------------------
// sfu_pkg
// Shared types and codes for the flap unit controller: request kinds, motor
// commands, calibration status codes and register indexes.
// ----------------------------------------------------------------------------
package sfu_pkg;

   // request kinds
   localparam logic [2:0] KIND_MOVE_LETTER = 3'd0;
   localparam logic [2:0] KIND_MOVE_FLAPS  = 3'd1;
   localparam logic [2:0] KIND_CAL_START   = 3'd2;
   localparam logic [2:0] KIND_CAL_POLL    = 3'd3;
   localparam logic [2:0] KIND_HALL_CHANGE = 3'd4;
   localparam logic [2:0] KIND_MS_TICK     = 3'd5;

   // motor commands
   localparam logic [2:0] CMD_NONE       = 3'd0;
   localparam logic [2:0] CMD_MOVE_REL   = 3'd1;
   localparam logic [2:0] CMD_RUN_FWD    = 3'd2;
   localparam logic [2:0] CMD_FORCE_STOP = 3'd3;
   localparam logic [2:0] CMD_HOME_MOVE  = 3'd4;

   // calibration status
   localparam logic [1:0] CAL_BUSY = 2'd0;
   localparam logic [1:0] CAL_DONE = 2'd1;
   localparam logic [1:0] CAL_FAIL = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_FLAP_STEP   = 2'd0;
   localparam logic [1:0] REG_CAL_OFFSET  = 2'd1;
   localparam logic [1:0] REG_CAL_TIMEOUT = 2'd2;
   localparam logic [1:0] REG_GLITCH_WIN  = 2'd3;

   // one whole step in Q.16
   localparam logic [17:0] ONE_Q16 = 18'h10000;

   typedef struct packed {
      logic [15:0] steps;
      logic [16:0] carry;
   } step_result_type;

endpackage

@@ hdl/sfu_step_conv.sv @@
// ----------------------------------------------------------------------------
// sfu_step_conv
// Converts a flap count into motor steps with a Q.16 steps-per-flap factor,
// carrying the fractional remainder and saturating the step count.
// ----------------------------------------------------------------------------
module sfu_step_conv (
   input  logic [9:0]                flaps,
   input  logic [23:0]               step_q16,
   input  logic [16:0]               carry,
   output sfu_pkg::step_result_type  result
);

   logic [33:0] prod;
   logic [17:0] whole;
   logic [17:0] carry_sum;
   logic        carry_over;
   logic [18:0] whole_adj;

   assign prod       = 34'(flaps) * 34'(step_q16);
   assign whole      = prod[33:16];
   assign carry_sum  = 18'(carry) + 18'(prod[15:0]);
   // an extra step only once the carry strictly exceeds one whole step
   assign carry_over = carry_sum > sfu_pkg::ONE_Q16;
   assign whole_adj  = 19'(whole) + 19'(carry_over);

   always_comb begin
      result.carry = carry_over ? 17'(carry_sum - sfu_pkg::ONE_Q16) : 17'(carry_sum);
      result.steps = (whole_adj > 19'd65535) ? 16'hFFFF : whole_adj[15:0];
   end

endmodule

@@ hdl/split_flap_unit_controller.sv @@
// ----------------------------------------------------------------------------
// split_flap_unit_controller
// Flap display unit controller: turns move, calibration, Hall and tick
// requests into motor commands and status for one stepper-driven drum.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one request per accepted beat (req_valid high,
//   req_stall low). Every request yields exactly one result on the rsp_
//   channel, in order. A request is captured in an input register and is
//   processed once the result register can advance, when the machine state
//   is updated and the result register is loaded with the result offered
//   on rsp_. One request per cycle is sustained while rsp_stall is low; the
//   single multiply of flap count by steps-per-flap sets the cycle time.
//   When the receiver holds rsp_stall, the result register holds, the input
//   register keeps its request and req_stall rises once it is full; nothing
//   is dropped.
//   The csr_ port writes the four registers (steps per flap, calibration
//   offset, calibration timeout, glitch window) at byte addresses 0, 4, 8
//   and 12; write it only while no request is in flight. Synchronous reset
//   empties both registers stages, restores register defaults and clears the
//   unit state (position 0, not calibrated, Hall level high).
// ----------------------------------------------------------------------------
module split_flap_unit_controller #(
   parameter int NUM_FLAPS = 45
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [5:0]  req_letter_index,
   input  logic [9:0]  req_flap_count,
   input  logic        req_hall_level,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_motor_cmd,
   output logic [15:0] rsp_move_steps,
   output logic [1:0]  rsp_cal_status,
   output logic        rsp_recalibrate_needed,
   output logic        rsp_hall_ok,
   output logic        rsp_pending_valid,
   output logic [5:0]  rsp_pending_index,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [23:0] flap_step_ff;
   logic [11:0] cal_offset_ff;
   logic [15:0] cal_timeout_ff;
   logic [9:0]  glitch_win_ff;
   logic        csr_write;

   // input stage
   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_kind_ff;
   logic [5:0]  s1_letter_ff;
   logic [9:0]  s1_flaps_ff;
   logic        s1_level_ff;
   logic        req_accept;
   logic        advance;
   logic        fire;

   // unit state
   logic [5:0]  flap_pos_ff, flap_pos_in;
   logic [16:0] step_carry_ff, step_carry_in;
   logic        cal_complete_ff, cal_complete_in;
   logic        cal_started_ff, cal_started_in;
   logic        pre_init_ff, pre_init_in;
   logic [15:0] cal_elapsed_ff, cal_elapsed_in;
   logic        hall_cur_ff, hall_cur_in;
   logic [15:0] since_hall_ff, since_hall_in;
   logic [5:0]  pend_letter_ff, pend_letter_in;
   logic        pend_valid_ff, pend_valid_in;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_cmd_ff, rsp_cmd_in;
   logic [15:0] rsp_steps_ff, rsp_steps_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_recal_ff, rsp_recal_in;
   logic        rsp_hall_ok_ff, rsp_hall_ok_in;

   // step conversion
   logic [5:0]                letter_eff;
   logic [5:0]                delta;
   logic [9:0]                conv_flaps;
   sfu_pkg::step_result_type  conv;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         flap_step_ff   <= 24'd2982616;
         cal_offset_ff  <= 12'd0;
         cal_timeout_ff <= 16'd12000;
         glitch_win_ff  <= 10'd100;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            sfu_pkg::REG_FLAP_STEP:   flap_step_ff   <= csr_pwdata[23:0];
            sfu_pkg::REG_CAL_OFFSET:  cal_offset_ff  <= csr_pwdata[11:0];
            sfu_pkg::REG_CAL_TIMEOUT: cal_timeout_ff <= csr_pwdata[15:0];
            sfu_pkg::REG_GLITCH_WIN:  glitch_win_ff  <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         sfu_pkg::REG_FLAP_STEP:   csr_prdata = 32'(flap_step_ff);
         sfu_pkg::REG_CAL_OFFSET:  csr_prdata = 32'(cal_offset_ff);
         sfu_pkg::REG_CAL_TIMEOUT: csr_prdata = 32'(cal_timeout_ff);
         sfu_pkg::REG_GLITCH_WIN:  csr_prdata = 32'(glitch_win_ff);
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // flow control
   // ---------------------------------------------------------------------
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && advance;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff   <= req_kind;
         s1_letter_ff <= req_letter_index;
         s1_flaps_ff  <= req_flap_count;
         s1_level_ff  <= req_hall_level;
      end
   end

   // ---------------------------------------------------------------------
   // request processing
   // ---------------------------------------------------------------------
   assign letter_eff = (s1_letter_ff >= 6'(NUM_FLAPS)) ? 6'd0 : s1_letter_ff;
   assign delta      = letter_eff - flap_pos_ff;
   assign conv_flaps = (s1_kind_ff == sfu_pkg::KIND_MOVE_LETTER) ? 10'(delta) : s1_flaps_ff;

   sfu_step_conv u_step_conv (
      .flaps    (conv_flaps),
      .step_q16 (flap_step_ff),
      .carry    (step_carry_ff),
      .result   (conv)
   );

   always_comb begin
      flap_pos_in     = flap_pos_ff;
      step_carry_in   = step_carry_ff;
      cal_complete_in = cal_complete_ff;
      cal_started_in  = cal_started_ff;
      pre_init_in     = pre_init_ff;
      cal_elapsed_in  = cal_elapsed_ff;
      hall_cur_in     = hall_cur_ff;
      since_hall_in   = since_hall_ff;
      pend_letter_in  = pend_letter_ff;
      pend_valid_in   = pend_valid_ff;
      rsp_cmd_in      = sfu_pkg::CMD_NONE;
      rsp_steps_in    = 16'd0;
      rsp_status_in   = cal_complete_ff ? sfu_pkg::CAL_DONE : sfu_pkg::CAL_BUSY;
      rsp_recal_in    = 1'b0;
      rsp_hall_ok_in  = 1'b1;

      case (s1_kind_ff)
         sfu_pkg::KIND_MOVE_LETTER: begin
            if (letter_eff < flap_pos_ff) begin
               // backward: hold the letter until recalibrated
               cal_complete_in = 1'b0;
               pend_letter_in  = letter_eff;
               pend_valid_in   = 1'b1;
               rsp_recal_in    = 1'b1;
               rsp_status_in   = sfu_pkg::CAL_BUSY;
            end else begin
               flap_pos_in    = letter_eff;
               step_carry_in  = conv.carry;
               rsp_cmd_in     = sfu_pkg::CMD_MOVE_REL;
               rsp_steps_in   = conv.steps;
               pend_letter_in = 6'd0;
               pend_valid_in  = 1'b0;
            end
         end
         sfu_pkg::KIND_MOVE_FLAPS: begin
            step_carry_in = conv.carry;
            rsp_cmd_in    = sfu_pkg::CMD_MOVE_REL;
            rsp_steps_in  = conv.steps;
         end
         sfu_pkg::KIND_CAL_START: begin
            cal_complete_in = 1'b0;
            cal_started_in  = 1'b1;
            cal_elapsed_in  = 16'd0;
            pre_init_in     = !hall_cur_ff;
            rsp_cmd_in      = sfu_pkg::CMD_RUN_FWD;
            rsp_status_in   = sfu_pkg::CAL_BUSY;
         end
         sfu_pkg::KIND_CAL_POLL: begin
            if (cal_complete_ff) begin
               rsp_status_in = sfu_pkg::CAL_DONE;
            end else if (cal_elapsed_ff > cal_timeout_ff) begin
               flap_pos_in     = 6'd0;
               cal_complete_in = 1'b1;
               cal_started_in  = 1'b0;
               rsp_cmd_in      = sfu_pkg::CMD_FORCE_STOP;
               rsp_status_in   = sfu_pkg::CAL_FAIL;
            end else if (pre_init_ff) begin
               // wait for the marker to pass before homing on it
               if (hall_cur_ff)
                  pre_init_in = 1'b0;
               rsp_status_in = sfu_pkg::CAL_BUSY;
            end else if (!hall_cur_ff) begin
               rsp_cmd_in      = sfu_pkg::CMD_HOME_MOVE;
               rsp_steps_in    = 16'(cal_offset_ff);
               flap_pos_in     = 6'd0;
               step_carry_in   = 17'd0;
               cal_complete_in = 1'b1;
               cal_started_in  = 1'b0;
               rsp_status_in   = sfu_pkg::CAL_DONE;
            end else begin
               rsp_status_in = sfu_pkg::CAL_BUSY;
            end
         end
         sfu_pkg::KIND_HALL_CHANGE: begin
            if (s1_level_ff != hall_cur_ff) begin
               hall_cur_in   = s1_level_ff;
               since_hall_in = 16'd0;
               if (since_hall_ff <= 16'(glitch_win_ff))
                  rsp_hall_ok_in = 1'b0;
            end
         end
         sfu_pkg::KIND_MS_TICK: begin
            if (cal_elapsed_ff != 16'hFFFF)
               cal_elapsed_in = cal_elapsed_ff + 16'd1;
            if (since_hall_ff != 16'hFFFF)
               since_hall_in = since_hall_ff + 16'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flap_pos_ff     <= 6'd0;
         step_carry_ff   <= 17'd0;
         cal_complete_ff <= 1'b0;
         cal_started_ff  <= 1'b0;
         pre_init_ff     <= 1'b0;
         cal_elapsed_ff  <= 16'd0;
         hall_cur_ff     <= 1'b1;
         since_hall_ff   <= 16'd0;
         pend_letter_ff  <= 6'd0;
         pend_valid_ff   <= 1'b0;
      end else if (fire) begin
         flap_pos_ff     <= flap_pos_in;
         step_carry_ff   <= step_carry_in;
         cal_complete_ff <= cal_complete_in;
         cal_started_ff  <= cal_started_in;
         pre_init_ff     <= pre_init_in;
         cal_elapsed_ff  <= cal_elapsed_in;
         hall_cur_ff     <= hall_cur_in;
         since_hall_ff   <= since_hall_in;
         pend_letter_ff  <= pend_letter_in;
         pend_valid_ff   <= pend_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_cmd_ff     <= rsp_cmd_in;
         rsp_steps_ff   <= rsp_steps_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_recal_ff   <= rsp_recal_in;
         rsp_hall_ok_ff <= rsp_hall_ok_in;
      end
   end

   // pending letter is reported as it stands after the request
   logic       rsp_pend_valid_ff;
   logic [5:0] rsp_pend_index_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pend_valid_ff <= pend_valid_in;
         rsp_pend_index_ff <= pend_letter_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_motor_cmd          = rsp_cmd_ff;
   assign rsp_move_steps         = rsp_steps_ff;
   assign rsp_cal_status         = rsp_status_ff;
   assign rsp_recalibrate_needed = rsp_recal_ff;
   assign rsp_hall_ok            = rsp_hall_ok_ff;
   assign rsp_pending_valid      = rsp_pend_valid_ff;
   assign rsp_pending_index      = rsp_pend_index_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_cal_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(cal_started_ff && cal_complete_ff))
      else $error("calibration started and complete at once");

   a_carry_bounded : assert property (@(posedge clock) disable iff (reset)
      step_carry_ff <= 17'h10000)
      else $error("step carry above one whole step");

   a_position_in_range : assert property (@(posedge clock) disable iff (reset)
      flap_pos_ff < 6'(NUM_FLAPS))
      else $error("flap position out of range");

   a_recal_sets_pending : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_recal_ff) |-> (rsp_pend_valid_ff && rsp_cmd_ff == sfu_pkg::CMD_NONE))
      else $error("recalibrate result without a pending letter");

   a_glitch_no_motion : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hall_ok_ff) |-> (rsp_cmd_ff == sfu_pkg::CMD_NONE))
      else $error("Hall glitch result carries a motor command");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flap unit controller. A driver feeds requests
// from a queue and a monitor checks every result against a cycle-free
// predictor of the unit. Both sides idle and stall at random. The run steps
// through several register settings: the extremes, the largest timeouts,
// Hall glitch boundaries and calibration with and without the marker present.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FLAP_COUNT = 45;
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] letter;
      logic [9:0] flaps;
      logic       hall;
   } flap_request_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] steps;
      logic [1:0]  status;
      logic        recal;
      logic        hall_ok;
      logic        pend_valid;
      logic [5:0]  pend_index;
   } unit_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [5:0]  req_letter_index = '0;
   logic [9:0]  req_flap_count = '0;
   logic        req_hall_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_motor_cmd;
   logic [15:0] rsp_move_steps;
   logic [1:0]  rsp_cal_status;
   logic        rsp_recalibrate_needed;
   logic        rsp_hall_ok;
   logic        rsp_pending_valid;
   logic [5:0]  rsp_pending_index;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   split_flap_unit_controller #(.NUM_FLAPS(FLAP_COUNT)) uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_letter_index       (req_letter_index),
      .req_flap_count         (req_flap_count),
      .req_hall_level         (req_hall_level),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_motor_cmd          (rsp_motor_cmd),
      .rsp_move_steps         (rsp_move_steps),
      .rsp_cal_status         (rsp_cal_status),
      .rsp_recalibrate_needed (rsp_recalibrate_needed),
      .rsp_hall_ok            (rsp_hall_ok),
      .rsp_pending_valid      (rsp_pending_valid),
      .rsp_pending_index      (rsp_pending_index),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted unit state and register copies
   logic [23:0] cfg_step = 24'd2982616;
   logic [11:0] cfg_offset = 12'd0;
   logic [15:0] cfg_timeout = 16'd12000;
   logic [9:0]  cfg_glitch = 10'd100;
   logic [5:0]  drum_pos = '0;
   logic [16:0] step_frac = '0;
   logic        calibrated = 1'b0;
   logic        marker_at_start = 1'b0;
   logic [15:0] cal_ms = '0;
   logic        hall_now = 1'b1;
   logic [15:0] hall_ms = '0;
   logic [5:0]  pend_letter = '0;
   logic        pend_valid = 1'b0;

   flap_request_type pending_requests[$];
   unit_result_type  expected_results[$];

   int  queued_count = 0;
   int  counted_requests = 0;
   int  accepted_count = 0;
   int  results_checked = 0;
   int  mismatch_count = 0;
   int  setting_count = 0;
   int  home_count = 0;
   int  timeout_count = 0;
   int  glitch_count = 0;
   int  recal_count = 0;
   logic gen_hall = 1'b1;
   bit   quiet_mode = 1'b0;
   int   long_hold_cycles = 0;
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;

   // Q.16 steps for a flap count; carry the fraction, saturate the count
   function automatic logic [15:0] steps_for_flaps(input logic [9:0] flaps);
      logic [33:0] product;
      logic [18:0] whole;
      product = 34'(flaps) * 34'(cfg_step);
      whole = 19'(product[33:16]);
      step_frac = step_frac + 17'(product[15:0]);
      if (step_frac > 17'h10000) begin
         whole = whole + 19'd1;
         step_frac = step_frac - 17'h10000;
      end
      return (whole > 19'd65535) ? 16'hFFFF : whole[15:0];
   endfunction

   function automatic unit_result_type apply_request(input flap_request_type rq);
      unit_result_type res;
      logic [5:0] target;
      logic [5:0] delta;
      res = '0;
      res.hall_ok = 1'b1;
      res.status = calibrated ? sfu_pkg::CAL_DONE : sfu_pkg::CAL_BUSY;
      case (rq.kind)
         sfu_pkg::KIND_MOVE_LETTER: begin
            target = (rq.letter >= FLAP_COUNT) ? 6'd0 : rq.letter;
            if (target < drum_pos) begin
               // backward: park the letter and ask for a new homing
               calibrated = 1'b0;
               pend_letter = target;
               pend_valid = 1'b1;
               res.recal = 1'b1;
            end else begin
               delta = target - drum_pos;
               drum_pos = target;
               res.cmd = sfu_pkg::CMD_MOVE_REL;
               res.steps = steps_for_flaps(10'(delta));
               pend_letter = '0;
               pend_valid = 1'b0;
            end
            res.status = calibrated ? sfu_pkg::CAL_DONE : sfu_pkg::CAL_BUSY;
         end
         sfu_pkg::KIND_MOVE_FLAPS: begin
            res.cmd = sfu_pkg::CMD_MOVE_REL;
            res.steps = steps_for_flaps(rq.flaps);
         end
         sfu_pkg::KIND_CAL_START: begin
            calibrated = 1'b0;
            cal_ms = '0;
            marker_at_start = !hall_now;
            res.cmd = sfu_pkg::CMD_RUN_FWD;
            res.status = sfu_pkg::CAL_BUSY;
         end
         sfu_pkg::KIND_CAL_POLL: begin
            if (calibrated) begin
               res.status = sfu_pkg::CAL_DONE;
            end else if (cal_ms > cfg_timeout) begin
               drum_pos = '0;
               calibrated = 1'b1;
               res.cmd = sfu_pkg::CMD_FORCE_STOP;
               res.status = sfu_pkg::CAL_FAIL;
            end else if (marker_at_start) begin
               // wait for the marker to pass before homing on it
               if (hall_now) marker_at_start = 1'b0;
               res.status = sfu_pkg::CAL_BUSY;
            end else if (!hall_now) begin
               res.cmd = sfu_pkg::CMD_HOME_MOVE;
               res.steps = 16'(cfg_offset);
               drum_pos = '0;
               step_frac = '0;
               calibrated = 1'b1;
               res.status = sfu_pkg::CAL_DONE;
            end else begin
               res.status = sfu_pkg::CAL_BUSY;
            end
         end
         sfu_pkg::KIND_HALL_CHANGE: begin
            if (rq.hall != hall_now) begin
               if (hall_ms <= 16'(cfg_glitch)) res.hall_ok = 1'b0;
               hall_now = rq.hall;
               hall_ms = '0;
            end
         end
         sfu_pkg::KIND_MS_TICK: begin
            if (cal_ms != 16'hFFFF) cal_ms = cal_ms + 16'd1;
            if (hall_ms != 16'hFFFF) hall_ms = hall_ms + 16'd1;
         end
         default: begin
         end
      endcase
      res.pend_valid = pend_valid;
      res.pend_index = pend_letter;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("error: result %0d: %s", results_checked, msg);
      mismatch_count++;
   endtask

   task automatic compare_result(input unit_result_type got, input unit_result_type want);
      if (got.cmd !== want.cmd)
         report_mismatch($sformatf("motor_cmd %0d, want %0d", got.cmd, want.cmd));
      if (got.steps !== want.steps)
         report_mismatch($sformatf("move_steps %0d, want %0d", got.steps, want.steps));
      if (got.status !== want.status)
         report_mismatch($sformatf("cal_status %0d, want %0d", got.status, want.status));
      if (got.recal !== want.recal)
         report_mismatch($sformatf("recalibrate_needed %b, want %b", got.recal, want.recal));
      if (got.hall_ok !== want.hall_ok)
         report_mismatch($sformatf("hall_ok %b, want %b", got.hall_ok, want.hall_ok));
      if (got.pend_valid !== want.pend_valid)
         report_mismatch($sformatf("pending_valid %b, want %b", got.pend_valid,
                                   want.pend_valid));
      if (got.pend_index !== want.pend_index)
         report_mismatch($sformatf("pending_index %0d, want %0d", got.pend_index,
                                   want.pend_index));
   endtask

   // idle draw: stretches with and without gaps
   function automatic int draw_idle(inout int stretch, inout bit idle_on);
      if (stretch == 0) begin
         stretch = $urandom_range(10, 60);
         idle_on = ($urandom_range(0, 3) != 0);
      end
      stretch--;
      return (idle_on && !quiet_mode) ? $urandom_range(0, 14) : 0;
   endfunction

   // request driver
   int req_gap = 0;
   int send_stretch = 0;
   bit send_idle = 1'b0;
   always @(negedge clock) begin
      flap_request_type rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            rq = pending_requests.pop_front();
            req_kind <= rq.kind;
            req_letter_index <= rq.letter;
            req_flap_count <= rq.flaps;
            req_hall_level <= rq.hall;
            req_valid <= 1'b1;
            req_gap = draw_idle(send_stretch, send_idle);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   int rsp_wait = 0;
   int recv_stretch = 0;
   bit recv_idle = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_took) rsp_wait = draw_idle(recv_stretch, recv_idle);
         if (long_hold_cycles > 0) begin
            long_hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: check results first, then predict the request taken at this edge
   always @(posedge clock) begin
      unit_result_type got;
      unit_result_type want;
      unit_result_type fresh;
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         rsp_took <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_motor_cmd, rsp_move_steps, rsp_cal_status, rsp_recalibrate_needed,
                    rsp_hall_ok, rsp_pending_valid, rsp_pending_index};
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               compare_result(got, want);
            end
            results_checked++;
         end
         if (req_valid && !req_stall) begin
            fresh = apply_request('{req_kind, req_letter_index, req_flap_count,
                                    req_hall_level});
            expected_results.push_back(fresh);
            accepted_count++;
            if (fresh.cmd == sfu_pkg::CMD_HOME_MOVE) home_count++;
            if (fresh.status == sfu_pkg::CAL_FAIL) timeout_count++;
            if (!fresh.hall_ok) glitch_count++;
            if (fresh.recal) recal_count++;
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         sfu_pkg::REG_FLAP_STEP:   cfg_step = value[23:0];
         sfu_pkg::REG_CAL_OFFSET:  cfg_offset = value[11:0];
         sfu_pkg::REG_CAL_TIMEOUT: cfg_timeout = value[15:0];
         sfu_pkg::REG_GLITCH_WIN:  cfg_glitch = value[9:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_registers(input logic [23:0] step, input logic [11:0] offset,
                                input logic [15:0] timeout, input logic [9:0] glitch);
      csr_write(sfu_pkg::REG_FLAP_STEP, 32'(step));
      csr_write(sfu_pkg::REG_CAL_OFFSET, 32'(offset));
      csr_write(sfu_pkg::REG_CAL_TIMEOUT, 32'(timeout));
      csr_write(sfu_pkg::REG_GLITCH_WIN, 32'(glitch));
      setting_count++;
   endtask

   // hold until every queued request is taken and answered
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_request(input logic [2:0] kind, input logic [5:0] letter,
                                input logic [9:0] flaps, input logic hall);
      pending_requests.push_back('{kind, letter, flaps, hall});
      queued_count++;
      if (kind <= sfu_pkg::KIND_MS_TICK) counted_requests++;
      if (kind == sfu_pkg::KIND_HALL_CHANGE) gen_hall = hall;
   endtask

   task automatic queue_kind(input logic [2:0] kind);
      queue_request(kind, 6'($urandom), 10'($urandom), 1'($urandom));
   endtask

   task automatic queue_letter(input logic [5:0] letter);
      queue_request(sfu_pkg::KIND_MOVE_LETTER, letter, 10'($urandom), 1'($urandom));
   endtask

   task automatic queue_flaps(input logic [9:0] flaps);
      queue_request(sfu_pkg::KIND_MOVE_FLAPS, 6'($urandom), flaps, 1'($urandom));
   endtask

   task automatic queue_hall(input logic level);
      queue_request(sfu_pkg::KIND_HALL_CHANGE, 6'($urandom), 10'($urandom), level);
   endtask

   task automatic queue_ticks(input int n);
      repeat (n) queue_kind(sfu_pkg::KIND_MS_TICK);
   endtask

   function automatic int pick_ticks();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
   endfunction

   task automatic queue_scene();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         repeat ($urandom_range(1, 4))
            queue_letter(($urandom_range(0, 7) == 0) ? 6'($urandom)
                                                     : 6'($urandom_range(0, FLAP_COUNT - 1)));
      end else if (pick < 40) begin
         repeat ($urandom_range(1, 3))
            queue_flaps(($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 50)));
      end else if (pick < 65) begin
         // calibration run: start, wander, then bring the marker in and poll
         if ($urandom_range(0, 2) != 0) queue_hall(1'b1);
         queue_kind(sfu_pkg::KIND_CAL_START);
         repeat ($urandom_range(0, 3)) begin
            queue_ticks(pick_ticks());
            if ($urandom_range(0, 1) != 0) queue_kind(sfu_pkg::KIND_CAL_POLL);
            else queue_hall(!gen_hall);
         end
         queue_ticks(pick_ticks());
         queue_hall(1'b0);
         repeat ($urandom_range(1, 2)) queue_kind(sfu_pkg::KIND_CAL_POLL);
         if ($urandom_range(0, 1) != 0) queue_hall(1'b1);
      end else if (pick < 85) begin
         repeat ($urandom_range(2, 6)) begin
            queue_ticks(pick_ticks());
            queue_hall(($urandom_range(0, 4) != 0) ? !gen_hall : gen_hall);
         end
      end else if (pick < 95) begin
         queue_ticks($urandom_range(1, 30));
      end else begin
         repeat ($urandom_range(1, 3)) queue_kind(3'($urandom));
      end
   endtask

   initial begin
      int target;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fraction carry: two half steps land exactly on one, the third spills
      csr_write(sfu_pkg::REG_FLAP_STEP, 32'h0000_8000);
      repeat (3) queue_flaps(10'd1);
      wait_idle();
      csr_write(sfu_pkg::REG_FLAP_STEP, 32'd2982616);

      // directed pass at the default settings
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      queue_hall(1'b1);
      queue_kind(KIND_SPARE_6);
      queue_kind(KIND_SPARE_7);
      queue_letter(6'd10);
      queue_letter(6'd5);
      queue_letter(6'd63);
      queue_letter(6'd44);
      queue_flaps(10'd0);
      queue_flaps(10'h3FF);
      queue_kind(sfu_pkg::KIND_CAL_START);
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      queue_hall(1'b0);
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      queue_kind(sfu_pkg::KIND_MS_TICK);
      queue_hall(1'b1);
      queue_hall(1'b0);
      queue_kind(sfu_pkg::KIND_CAL_START);
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      queue_hall(1'b1);
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      queue_hall(1'b0);
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      // glitch window edge: a gap of exactly the window is a glitch, one more is not
      queue_ticks(100);
      queue_hall(1'b1);
      queue_ticks(101);
      queue_hall(1'b0);
      wait_idle();

      // largest timeouts: a short calibration wait stays in progress
      quiet_mode = 1'b1;
      csr_write(sfu_pkg::REG_CAL_TIMEOUT, 32'h0000_FFFF);
      queue_hall(1'b1);
      queue_kind(sfu_pkg::KIND_CAL_START);
      queue_ticks(40);
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      wait_idle();
      csr_write(sfu_pkg::REG_CAL_TIMEOUT, 32'h0000_FFFE);
      queue_kind(sfu_pkg::KIND_CAL_POLL);
      queue_hall(1'b0);
      wait_idle();
      quiet_mode = 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            0: set_registers(24'hFFFFFF, 12'hFFF, 16'd0, 10'd0);
            1: set_registers(24'd0, 12'd0, 16'hFFFF, 10'h3FF);
            2: set_registers(24'd2982616, 12'd37, 16'd12, 10'd4);
            default: set_registers(($urandom_range(0, 3) == 0) ? 24'($urandom)
                                      : 24'($urandom_range(32'h8000, 32'h80000)),
                                   12'($urandom), 16'($urandom_range(0, 25)),
                                   10'($urandom_range(0, 12)));
         endcase
         if (ph == 0) begin
            queue_flaps(10'h3FF);
            queue_hall(1'b1);
            queue_kind(sfu_pkg::KIND_CAL_START);
            queue_kind(sfu_pkg::KIND_MS_TICK);
            queue_kind(sfu_pkg::KIND_CAL_POLL);
            queue_hall(1'b0);
            queue_hall(1'b1);
            queue_kind(sfu_pkg::KIND_MS_TICK);
            queue_hall(1'b0);
         end
         if (ph == 2) begin
            // back up the result side while requests keep coming
            @(posedge clock);
            long_hold_cycles = 150;
         end
         target = counted_requests + 175;
         while (counted_requests < target) begin
            queue_scene();
            // pause the sender mid-phase until everything has come back
            if (ph == 3 && counted_requests >= target - 110 && counted_requests < target - 100)
               wait_idle();
         end
      end
      wait_idle();
      repeat (6) @(posedge clock);

      $display("covered %0d requests under %0d register settings, %0d results compared",
               accepted_count, setting_count + 1, results_checked);
      $display("homings %0d, calibration timeouts %0d, Hall glitches %0d, backward moves %0d",
               home_count, timeout_count, glitch_count, recal_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("split_flap_unit_controller: match");
      end else begin
         $display("split_flap_unit_controller: mismatch");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("split_flap_unit_controller: mismatch");
      $finish;
   end

endmodule
